@@ sv/epr_pkg.sv @@
// Shared types and constants for the encoder position and speed block.
// Used by the serial divider, the serial multiplier and the top level.
`timescale 1ns / 1ps

package epr_pkg;

  // Item operations.
  localparam logic [1:0] OP_EDGE   = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_PULSES_PER_TURN = 1'b0;
  localparam logic CFG_PHASE_FLIP      = 1'b1;

  localparam int POS_W   = 32;
  localparam int PPT_W   = 16;
  localparam int SCALE_W = 16;
  localparam int PROD_W  = POS_W + SCALE_W;
  localparam int STEP_W  = $clog2(PROD_W + 1);

  localparam logic [SCALE_W-1:0] MS_PER_MINUTE = 16'd60000;

  // Quotient bits produced per division.
  localparam logic [STEP_W-1:0] SCALE_STEPS = STEP_W'(SCALE_W);
  localparam logic [STEP_W-1:0] SPEED_STEPS = STEP_W'(PROD_W);

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_ctl_t;

endpackage

@@ sv/encoder_position_and_rpm.sv @@
// Top level of the encoder position counter with speed estimate.
// Instantiates epr_div and epr_mul; uses epr_pkg.
`timescale 1ns / 1ps

// Encoder edge, clear and unused operations finish in the cycle they are
// accepted and their result is in the output register on the next cycle.
// A speed sample runs a 16-step division of 60000 by the elapsed time, a
// 16-step multiply of the distance by that scale, and a 48-step division
// by pulses_per_turn, the two divisions sharing one serial
// divider that makes one quotient bit per cycle. A sample with zero elapsed
// time finishes at once. A new item is taken only when the block is idle and
// the output register is free or being emptied in that cycle.
module encoder_position_and_rpm (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         operation,
  input  logic               phase_level,
  input  logic [31:0]        now_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] position,
  output logic signed [31:0] speed_rpm,
  output logic               time_error,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);
  import epr_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SCALE, S_MUL, S_SPEED, S_OUT} state_t;

  state_t             state;
  logic [PPT_W-1:0]   ppt;
  logic               phase_flip;
  logic [POS_W-1:0]   count_position;
  logic [POS_W-1:0]   sample_position;
  logic [POS_W-1:0]   sample_time;
  logic [POS_W-1:0]   speed_value;
  logic [POS_W-1:0]   travel;
  logic               forward;

  logic               accept;
  logic               out_free;
  logic               out_load;
  logic [POS_W-1:0]   elapsed;
  logic [POS_W:0]     diff;
  logic [POS_W:0]     diff_neg;
  logic               fwd_next;
  logic [POS_W-1:0]   count_next;
  logic [PPT_W-1:0]   ppt_eff;
  logic [POS_W-1:0]   speed_next;

  div_ctl_t           div_ctl;
  logic [PROD_W-1:0]  div_dividend;
  logic [POS_W-1:0]   div_divisor;
  logic [PROD_W-1:0]  div_quot;
  logic               div_done;
  logic               mul_start;
  logic [PROD_W-1:0]  mul_prod;
  logic               mul_done;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign elapsed  = now_ms - sample_time;

  // A result is loaded either straight from an accepted item or after a sample.
  assign out_load = (state == S_IDLE)
                  ? (accept && !((operation == OP_SAMPLE) && (elapsed != '0)))
                  : ((state == S_OUT) && out_free);

  // The distance is formed at 33 bits so it never wraps.
  assign diff     = {count_position[POS_W-1], count_position}
                  - {sample_position[POS_W-1], sample_position};
  assign diff_neg = -diff;
  assign fwd_next = !diff[POS_W] && (diff != '0);
  assign ppt_eff  = (ppt == '0) ? PPT_W'(1) : ppt;

  always_comb begin
    case (operation)
      OP_EDGE:  count_next = (phase_level == phase_flip) ? count_position - 1'b1
                                                         : count_position + 1'b1;
      OP_CLEAR: count_next = '0;
      default:  count_next = count_position;
    endcase
  end

  // The divider serves both the time scale and the final speed division.
  always_comb begin
    div_ctl.start = 1'b0;
    div_ctl.steps = SCALE_STEPS;
    div_dividend  = {MS_PER_MINUTE, {POS_W{1'b0}}};
    div_divisor   = elapsed;
    if (state == S_IDLE) begin
      div_ctl.start = accept && (operation == OP_SAMPLE) && (elapsed != '0);
    end else begin
      div_ctl.start = (state == S_MUL) && mul_done;
      div_ctl.steps = SPEED_STEPS;
      div_dividend  = mul_prod;
      div_divisor   = {{(POS_W - PPT_W){1'b0}}, ppt_eff};
    end
  end

  assign mul_start = (state == S_SCALE) && div_done;

  always_comb begin
    if (forward) begin
      speed_next = (div_quot[PROD_W-1:POS_W-1] != '0) ? 32'h7FFF_FFFF
                                                      : div_quot[POS_W-1:0];
    end else begin
      speed_next = (div_quot[PROD_W-1:POS_W-1] != '0) ? 32'h8000_0000
                                                      : -div_quot[POS_W-1:0];
    end
  end

  epr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quot),
    .done     (div_done)
  );

  epr_mul u_mul (
    .clk          (clk),
    .rst          (rst),
    .start        (mul_start),
    .multiplicand (travel),
    .multiplier   (div_quot[SCALE_W-1:0]),
    .product      (mul_prod),
    .done         (mul_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      ppt             <= PPT_W'(1);
      phase_flip      <= 1'b0;
      count_position  <= '0;
      sample_position <= '0;
      sample_time     <= '0;
      speed_value     <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PULSES_PER_TURN: ppt        <= cfg_data;
          CFG_PHASE_FLIP:      phase_flip <= cfg_data[0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            count_position <= count_next;
            if ((operation == OP_SAMPLE) && (elapsed != '0)) begin
              sample_position <= count_position;
              sample_time     <= now_ms;
              travel          <= fwd_next ? diff[POS_W-1:0] : diff_neg[POS_W-1:0];
              forward         <= fwd_next;
              state           <= S_SCALE;
            end else begin
              if (operation == OP_SAMPLE) begin
                sample_position <= count_position;
                sample_time     <= now_ms;
              end
              position   <= count_next;
              speed_rpm  <= speed_value;
              time_error <= (operation == OP_SAMPLE);
            end
          end
        end
        S_SCALE: begin
          if (div_done) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_done) begin
            state <= S_SPEED;
          end
        end
        S_SPEED: begin
          if (div_done) begin
            speed_value <= speed_next;
            state       <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            position   <= count_position;
            speed_rpm  <= speed_value;
            time_error <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A sample with time elapsed must start the serial scale division.
  a_sample_starts: assert property (@(posedge clk) disable iff (rst)
    accept && (operation == OP_SAMPLE) && (now_ms != sample_time) |=> state == S_SCALE)
    else $error("speed sample did not start the scale division");

  // A waiting result always shows the live position.
  a_pos_live: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> position == count_position)
    else $error("output position differs from the counter");

  // A zero-time sample leaves the speed as it was.
  a_fault_speed: assert property (@(posedge clk) disable iff (rst)
    out_valid && time_error |-> speed_rpm == speed_value)
    else $error("speed changed on a zero elapsed time sample");

  // The multiplier only runs between the two divisions.
  a_mul_order: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == S_MUL)
    else $error("multiplier finished outside its phase");

endmodule

@@ sv/epr_div.sv @@
// Restoring divider that produces one quotient bit per cycle.
// Depends on epr_pkg for widths and the control struct.
`timescale 1ns / 1ps

module epr_div (
  input  logic                      clk,
  input  logic                      rst,
  input  epr_pkg::div_ctl_t         ctl,
  input  logic [epr_pkg::PROD_W-1:0] dividend,
  input  logic [epr_pkg::POS_W-1:0]  divisor,
  output logic [epr_pkg::PROD_W-1:0] quotient,
  output logic                      done
);
  import epr_pkg::*;

  // The dividend shifts out at the top while quotient bits shift in at the
  // bottom, so after n steps the low n bits hold the quotient.
  logic [PROD_W-1:0] work;
  logic [POS_W-1:0]  rem;
  logic [POS_W-1:0]  dvsr;
  logic [STEP_W-1:0] cnt;
  logic              busy;
  logic [POS_W:0]    shifted;
  logic              fits;
  logic [POS_W:0]    diff_next;

  assign shifted   = {rem, work[PROD_W-1]};
  assign fits      = shifted >= {1'b0, dvsr};
  assign diff_next = shifted - {1'b0, dvsr};
  assign quotient  = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        work <= dividend;
        rem  <= '0;
        dvsr <= divisor;
        cnt  <= ctl.steps;
        busy <= 1'b1;
      end else if (busy) begin
        work <= {work[PROD_W-2:0], fits};
        rem  <= fits ? diff_next[POS_W-1:0] : shifted[POS_W-1:0];
        cnt  <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ sv/epr_mul.sv @@
// Shift-and-add multiplier that consumes one multiplier bit per cycle.
// Depends on epr_pkg for the operand and product widths.
`timescale 1ns / 1ps

module epr_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [epr_pkg::POS_W-1:0]   multiplicand,
  input  logic [epr_pkg::SCALE_W-1:0] multiplier,
  output logic [epr_pkg::PROD_W-1:0]  product,
  output logic                        done
);
  import epr_pkg::*;

  localparam int CNT_W = $clog2(SCALE_W + 1);

  logic [PROD_W-1:0]  acc;
  logic [POS_W-1:0]   mcand;
  logic [SCALE_W-1:0] mbits;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic [PROD_W-1:0]  addend;

  // Multiplier bits are taken most significant first.
  assign addend  = mbits[SCALE_W-1] ? {{SCALE_W{1'b0}}, mcand} : '0;
  assign product = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        acc   <= '0;
        mcand <= multiplicand;
        mbits <= multiplier;
        cnt   <= CNT_W'(SCALE_W);
        busy  <= 1'b1;
      end else if (busy) begin
        acc   <= {acc[PROD_W-2:0], 1'b0} + addend;
        mbits <= {mbits[SCALE_W-2:0], 1'b0};
        cnt   <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for encoder_position_and_rpm: directed table, random phases
// and a closing count-up run, checked against typed table rows or a built-in speed predictor.
// Depends on epr_pkg and the encoder_position_and_rpm RTL.
`timescale 1ns / 1ps

module tb;
  import epr_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 200;
  localparam int SWEEP_EDGES = 40;
  localparam int MAX_REPORTS = 100;
  localparam int NUM_ROWS = 22;

  typedef struct {
    logic signed [31:0] pos;
    logic signed [31:0] spd;
    logic               err;
  } enc_result_t;

  typedef struct {
    logic [1:0]  op;
    logic        lvl;
    logic [31:0] now;
    bit          typed;
    int          pos;
    int          spd;
    bit          err;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [1:0] operation;
  logic phase_level;
  logic [31:0] now_ms;
  logic out_valid;
  logic out_ready;
  logic signed [31:0] position;
  logic signed [31:0] speed_rpm;
  logic time_error;
  logic cfg_we;
  logic cfg_index;
  logic [15:0] cfg_data;

  // Predictor copy of the block's state and registers.
  logic [15:0]        m_ppt;
  logic               m_flip;
  logic signed [31:0] m_pos;
  logic signed [31:0] m_spos;
  logic [31:0]        m_time;
  logic signed [31:0] m_speed;

  enc_result_t expected_readings[$];
  int fail_count = 0;
  int idle_cycles = 0;
  int hold_requests = 0;
  int hold_served = 0;

  // Expectation typed into the directed table, attached to the item on the bus.
  bit          cur_typed;
  enc_result_t cur_typed_result;
  // Expectation for the next item, moved onto the bus when that item is driven.
  bit          next_typed;
  enc_result_t next_typed_result;

  dir_row_t directed_rows [NUM_ROWS] = '{
    '{OP_SAMPLE, 1'b0, 32'd0,          1'b1, 0,  0,      1'b1},
    '{OP_EDGE,   1'b0, 32'd0,          1'b1, -1, 0,      1'b0},
    '{OP_EDGE,   1'b1, 32'd0,          1'b1, 0,  0,      1'b0},
    '{OP_EDGE,   1'b1, 32'd0,          1'b1, 1,  0,      1'b0},
    '{OP_SAMPLE, 1'b0, 32'd1,          1'b1, 1,  60000,  1'b0},
    '{OP_CLEAR,  1'b1, 32'd0,          1'b1, 0,  60000,  1'b0},
    '{OP_UNUSED, 1'b1, 32'hFFFF_FFFF,  1'b1, 0,  60000,  1'b0},
    '{OP_SAMPLE, 1'b0, 32'd1,          1'b1, 0,  60000,  1'b1},
    '{OP_EDGE,   1'b0, 32'd0,          1'b1, -1, 60000,  1'b0},
    '{OP_SAMPLE, 1'b1, 32'd60001,      1'b1, -1, -1,     1'b0},
    '{OP_SAMPLE, 1'b0, 32'd120002,     1'b1, -1, 0,      1'b0},
    '{OP_EDGE,   1'b1, 32'hFFFF_FFFF,  1'b1, 0,  0,      1'b0},
    '{OP_EDGE,   1'b1, 32'd0,          1'b1, 1,  0,      1'b0},
    '{OP_EDGE,   1'b1, 32'd0,          1'b1, 2,  0,      1'b0},
    '{OP_SAMPLE, 1'b1, 32'd120003,     1'b1, 2,  180000, 1'b0},
    '{OP_SAMPLE, 1'b0, 32'hFFFF_FFFF,  1'b1, 2,  0,      1'b0},
    '{OP_SAMPLE, 1'b0, 32'd1,          1'b0, 0,  0,      1'b0},
    '{OP_EDGE,   1'b1, 32'd0,          1'b0, 0,  0,      1'b0},
    '{OP_SAMPLE, 1'b0, 32'd3,          1'b0, 0,  0,      1'b0},
    '{OP_CLEAR,  1'b0, 32'h5A5A_A5A5,  1'b0, 0,  0,      1'b0},
    '{OP_SAMPLE, 1'b1, 32'd13,         1'b0, 0,  0,      1'b0},
    '{OP_UNUSED, 1'b0, 32'd0,          1'b0, 0,  0,      1'b0}
  };

  encoder_position_and_rpm DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .phase_level (phase_level),
    .now_ms      (now_ms),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .position    (position),
    .speed_rpm   (speed_rpm),
    .time_error  (time_error),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Applies one item to the predicted state and returns the reading it produces.
  function automatic enc_result_t advance_encoder(logic [1:0] op, logic lvl, logic [31:0] now);
    enc_result_t r;
    logic [31:0] elapsed;
    longint cur, last, travel;
    longint unsigned scale, divisor, mag;
    bit forward;
    r.err = 1'b0;
    case (op)
      OP_EDGE: begin
        if (lvl == m_flip) m_pos = m_pos - 32'sd1;
        else m_pos = m_pos + 32'sd1;
      end
      OP_CLEAR: m_pos = '0;
      OP_SAMPLE: begin
        elapsed = now - m_time;
        if (elapsed == 32'd0) begin
          r.err = 1'b1;
        end else begin
          cur = longint'(m_pos);
          last = longint'(m_spos);
          forward = cur > last;
          travel = forward ? cur - last : last - cur;
          scale = 64'(32'(MS_PER_MINUTE) / elapsed);
          divisor = (m_ppt == 16'd0) ? 64'd1 : 64'(m_ppt);
          mag = (64'(travel) * scale) / divisor;
          if (forward) m_speed = (mag > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : mag[31:0];
          else if (mag >= 64'h8000_0000) m_speed = 32'sh8000_0000;
          else m_speed = 32'd0 - mag[31:0];
        end
        m_spos = m_pos;
        m_time = now;
      end
      default: ;
    endcase
    r.pos = m_pos;
    r.spd = m_speed;
    return r;
  endfunction

  // Predictor, scoreboard and watchdog, all sampled at the rising edge.
  always @(posedge clk) begin
    enc_result_t want, got;
    if (rst) begin
      m_ppt <= 16'd1;
      m_flip <= 1'b0;
      m_pos = '0;
      m_spos = '0;
      m_time = '0;
      m_speed = '0;
      idle_cycles <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_PULSES_PER_TURN) m_ppt <= cfg_data;
        else m_flip <= cfg_data[0];
      end
      // Pop before push: a result leaving this cycle belongs to an older transfer.
      if (out_valid && out_ready) begin
        got.pos = position;
        got.spd = speed_rpm;
        got.err = time_error;
        if (expected_readings.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: unexpected result, actual pos %0d speed %0d err %0b",
                     $time, got.pos, got.spd, got.err);
        end else begin
          want = expected_readings.pop_front();
          if (got.pos !== want.pos || got.spd !== want.spd || got.err !== want.err) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              if (got.pos !== want.pos)
                $display("%0t: position expected %0d actual %0d", $time, want.pos, got.pos);
              if (got.spd !== want.spd)
                $display("%0t: speed_rpm expected %0d actual %0d", $time, want.spd, got.spd);
              if (got.err !== want.err)
                $display("%0t: time_error expected %0b actual %0b", $time, want.err, got.err);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        want = advance_encoder(operation, phase_level, now_ms);
        expected_readings.push_back(cur_typed ? cur_typed_result : want);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d results outstanding",
                 $time, expected_readings.size());
        $display("** encoder_position_and_rpm: FAILED **");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Result side: random stalls, calm stretches, and long hold-offs on request.
  initial begin
    int hold_left, busy_left, free_left, r;
    hold_left = 0;
    busy_left = 0;
    free_left = 0;
    out_ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (hold_requests != hold_served) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (busy_left > 0) begin
        out_ready = 1'b0;
        busy_left--;
      end else if (free_left > 0) begin
        out_ready = 1'b1;
        free_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_ready = 1'b1;
        end else if (r < 75) begin
          out_ready = 1'b1;
          free_left = $urandom_range(20, 200);
        end else if (r < 95) begin
          out_ready = 1'b0;
          busy_left = $urandom_range(0, 3);
        end else begin
          out_ready = 1'b0;
          busy_left = $urandom_range(10, 80);
        end
      end
    end
  end

  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Offers one item after an idle gap and returns once it has been transferred.
  task automatic send_item(logic [1:0] op, logic lvl, logic [31:0] now, int gap);
    for (int g = 0; g < gap; g++) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    operation = op;
    phase_level = lvl;
    now_ms = now;
    cur_typed = next_typed;
    cur_typed_result = next_typed_result;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_readings.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    logic [15:0] ppt_choice [8];
    logic [31:0] last_now, now, elapsed;
    logic [1:0]  op;
    logic        lvl, flip, run_up;
    int          run_left, r;
    bit          calm;

    rst = 1'b1;
    in_valid = 1'b0;
    operation = OP_EDGE;
    phase_level = 1'b0;
    now_ms = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_PULSES_PER_TURN;
    cfg_data = '0;
    cur_typed = 1'b0;
    cur_typed_result = '{default: '0};
    next_typed = 1'b0;
    next_typed_result = '{default: '0};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table with the reset settings: one count per pulse, phase-B low counts down.
    last_now = '0;
    foreach (directed_rows[i]) begin
      next_typed = directed_rows[i].typed;
      next_typed_result.pos = directed_rows[i].pos;
      next_typed_result.spd = directed_rows[i].spd;
      next_typed_result.err = directed_rows[i].err;
      send_item(directed_rows[i].op, directed_rows[i].lvl, directed_rows[i].now, pick_gap(0));
      if (directed_rows[i].op == OP_SAMPLE) last_now = directed_rows[i].now;
    end
    next_typed = 1'b0;

    ppt_choice[0] = 16'd65535;
    ppt_choice[1] = 16'd0;
    ppt_choice[2] = 16'd1;
    ppt_choice[3] = 16'd360;
    ppt_choice[4] = 16'd2;
    ppt_choice[5] = 16'($urandom_range(1, 65535));
    ppt_choice[6] = 16'($urandom_range(1, 64));
    ppt_choice[7] = 16'($urandom);

    run_left = 0;
    run_up = 1'b1;
    for (int p = 0; p < 8; p++) begin
      wait_drained();
      flip = (p < 2) ? p[0] : 1'($urandom);
      write_reg(CFG_PULSES_PER_TURN, ppt_choice[p]);
      write_reg(CFG_PHASE_FLIP, {15'($urandom), flip});
      if (p == 2 || p == 6) hold_requests++;
      calm = (p % 4 == 3);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        lvl = 1'($urandom);
        now = $urandom;
        if (r < 65) begin
          // Motion comes in runs in one direction, with some jitter mixed in.
          op = OP_EDGE;
          if (run_left == 0) begin
            run_up = 1'($urandom);
            run_left = $urandom_range(1, 60);
          end
          run_left--;
          if ($urandom_range(0, 99) < 85) lvl = run_up ? ~flip : flip;
        end else if (r < 83) begin
          op = OP_SAMPLE;
          r = $urandom_range(0, 99);
          if (r < 5) elapsed = 32'd0;
          else if (r < 55) elapsed = $urandom_range(1, 50);
          else if (r < 80) elapsed = $urandom_range(51, 60000);
          else if (r < 90) elapsed = $urandom_range(60001, 32'hFFFF_FFFF);
          else elapsed = now - last_now;
          now = last_now + elapsed;
          last_now = now;
        end else if (r < 93) begin
          op = OP_CLEAR;
        end else begin
          op = OP_UNUSED;
        end
        send_item(op, lvl, now, pick_gap(calm));
        if ($urandom_range(0, 99) == 0) wait_drained();
      end
    end

    // Count-up run sampled over one millisecond, then a clear for a downward sample.
    wait_drained();
    write_reg(CFG_PULSES_PER_TURN, 16'd1);
    write_reg(CFG_PHASE_FLIP, 16'd0);
    hold_requests++;
    for (int k = 0; k < SWEEP_EDGES; k++)
      send_item(OP_EDGE, 1'b1, $urandom, ($urandom_range(0, 99) < 97) ? 0 : 2);
    last_now = last_now + 32'd1;
    send_item(OP_SAMPLE, 1'b0, last_now, 0);
    send_item(OP_CLEAR, 1'b1, $urandom, 0);
    last_now = last_now + 32'd1;
    send_item(OP_SAMPLE, 1'b1, last_now, 0);
    last_now = last_now + 32'd1;
    send_item(OP_SAMPLE, 1'b0, last_now, 3);

    wait_drained();
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("** encoder_position_and_rpm: PASSED **");
    end else begin
      $display("** encoder_position_and_rpm: FAILED **");
    end
    $finish;
  end

endmodule

@@ encoder_position_and_rpm.f @@
sv/epr_pkg.sv
sv/epr_div.sv
sv/epr_mul.sv
sv/encoder_position_and_rpm.sv
sim/tb.sv
